/* rtl/core/sdc_pkg.sv */
`timescale 1ns / 1ps
// sdc_pkg: shared types, constants and round functions for the differential cascade
// no dependencies
package sdc_pkg;

  localparam int WordW  = 32;
  localparam int NCells = 15;

  typedef logic [WordW-1:0] word_t;

  localparam word_t FirstWordReset = 32'hc5bde324;

  typedef struct packed {
    word_t a, b, c, d, e, f, g, h;
  } sha_state_t;

  // one slot of the round pipeline
  typedef struct packed {
    logic       valid;
    sha_state_t sn;
    sha_state_t sf;
    word_t      cand;
    word_t      acc;
    word_t      wf;
  } pipe_t;

  typedef struct packed {
    word_t round17_difference;
    logic  hit;
    word_t candidate_echo;
  } result_t;

  localparam sha_state_t InitHash = '{
    a: 32'h6a09e667, b: 32'hbb67ae85, c: 32'h3c6ef372, d: 32'ha54ff53a,
    e: 32'h510e527f, f: 32'h9b05688c, g: 32'h1f83d9ab, h: 32'h5be0cd19};

  localparam word_t RoundK [16] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174};

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // one compression round
  function automatic sha_state_t sha_round(sha_state_t s, word_t w, word_t k);
    word_t s1, ch, t1, s0, mj;
    sha_state_t r;
    s1 = rotr(s.e, 6) ^ rotr(s.e, 11) ^ rotr(s.e, 25);
    ch = (s.e & s.f) ^ (~s.e & s.g);
    t1 = s.h + s1 + ch + k + w;
    s0 = rotr(s.a, 2) ^ rotr(s.a, 13) ^ rotr(s.a, 22);
    mj = (s.a & s.b) ^ (s.a & s.c) ^ (s.b & s.c);
    r.h = s.g; r.g = s.f; r.f = s.e; r.e = s.d + t1;
    r.d = s.c; r.c = s.b; r.b = s.a; r.a = t1 + s0 + mj;
    return r;
  endfunction

endpackage

/* rtl/core/sdc_if.sv */
`timescale 1ns / 1ps
// sdc_if: valid/ready channel interfaces for candidates, results and configuration
// depends on sdc_pkg
interface sdc_in_if;
  logic             valid;
  logic             ready;
  sdc_pkg::word_t   candidate;
  modport source (output valid, candidate, input ready);
  modport sink   (input valid, candidate, output ready);
endinterface

interface sdc_out_if;
  logic             valid;
  logic             ready;
  sdc_pkg::word_t   round17_difference;
  logic             hit;
  sdc_pkg::word_t   candidate_echo;
  modport source (output valid, round17_difference, hit, candidate_echo, input ready);
  modport sink   (input valid, round17_difference, hit, candidate_echo, output ready);
endinterface

interface sdc_cfg_if;
  logic             valid;
  logic             ready;
  sdc_pkg::word_t   data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/sdc_cell.sv */
`timescale 1ns / 1ps
// sdc_cell: one round of the normal and faulty states, registered
// depends on sdc_pkg
module sdc_cell #(
  parameter int Idx = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  sdc_pkg::word_t first_word,
  input  sdc_pkg::pipe_t prev,
  output sdc_pkg::pipe_t cur
);
  import sdc_pkg::*;

  sha_state_t sn_next, sf0, sf_next;
  word_t      wn, wf0, delta, acc_next, wf_next;

  // message words of this round
  always_comb begin
    wn  = '0;
    wf0 = '0;
    if (Idx == 0) begin
      wn  = first_word;
      wf0 = first_word + 32'd1;
    end else if (Idx == 1) begin
      wn  = prev.cand;
      wf0 = prev.cand;
    end
  end

  // round on both states, later rounds cancel the e difference
  always_comb begin
    sn_next = sha_round(prev.sn, wn, RoundK[Idx]);
    sf0     = sha_round(prev.sf, wf0, RoundK[Idx]);
    delta   = '0;
    sf_next = sf0;
    if (Idx >= 2) begin
      delta     = sn_next.e - sf0.e;
      sf_next.e = sn_next.e;
      sf_next.a = sf0.a + delta;
    end
    wf_next  = delta;
    acc_next = prev.acc;
    if (Idx == 9)  acc_next = prev.acc + delta;
    if (Idx == 12) acc_next = prev.acc + (sf_next.a - sn_next.a);
  end

  // valid flag and payload
  always_ff @(posedge clk) begin
    if (en) begin
      cur.sn   <= sn_next;
      cur.sf   <= sf_next;
      cur.cand <= prev.cand;
      cur.acc  <= acc_next;
      cur.wf   <= wf_next;
    end
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur.valid <= prev.valid;
    end
  end

endmodule

/* rtl/core/sdc_outbuf.sv */
`timescale 1ns / 1ps
// sdc_outbuf: two-entry result buffer, finishes the word 16 term
// depends on sdc_pkg, sdc_if
module sdc_outbuf (
  input  logic           clk,
  input  logic           rst,
  input  sdc_pkg::pipe_t last,
  input  logic           en,
  output logic           full,
  sdc_out_if.source      out
);
  import sdc_pkg::*;

  result_t    buf_q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;
  result_t    res;
  word_t      diff;

  assign push = en && last.valid;
  assign pop  = out.valid && out.ready;
  assign full = (count == 2'd2);

  // word 16 difference is sigma1 of word 14 offset plus the accumulated word 9 and round 12 terms plus one
  always_comb begin
    diff                   = last.acc + small_sigma1(last.wf) + 32'd1;
    res.round17_difference = diff;
    res.hit                = (diff == '0);
    res.candidate_echo     = last.cand;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) buf_q[wr_ptr] <= res;
  end

  assign out.valid              = (count != 2'd0);
  assign out.round17_difference = buf_q[rd_ptr].round17_difference;
  assign out.hit                = buf_q[rd_ptr].hit;
  assign out.candidate_echo     = buf_q[rd_ptr].candidate_echo;

endmodule

/* rtl/core/sha256_diff_cascade_de17.sv */
`timescale 1ns / 1ps
// sha256_diff_cascade_de17: top level, chain of fifteen round cells and result buffer
// depends on sdc_pkg, sdc_if, sdc_cell, sdc_outbuf
//
//  channel | dir | payload
//  in      | in  | candidate
//  out     | out | round17_difference, hit, candidate_echo
//  cfg     | in  | data (first_word), always ready
//
// one candidate per cycle while in.ready is high; a result passes fifteen round cells plus the buffer
// the cell chain advances as one while the two-entry buffer has room
// when out stalls the buffer fills and in.ready drops; no path from out.ready to in.ready
// synchronous reset clears valid flags and buffer count, and restores first_word
module sha256_diff_cascade_de17 (
  input  logic      clk,
  input  logic      rst,
  sdc_in_if.sink    in,
  sdc_out_if.source out,
  sdc_cfg_if.sink   cfg
);
  import sdc_pkg::*;

  word_t first_word;
  pipe_t stage [NCells+1];
  logic  en, full;

  // configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      first_word <= FirstWordReset;
    end else if (cfg.valid) begin
      first_word <= cfg.data;
    end
  end

  assign en       = !full;
  assign in.ready = en;

  // chain entry
  always_comb begin
    stage[0].valid = in.valid;
    stage[0].sn    = InitHash;
    stage[0].sf    = InitHash;
    stage[0].cand  = in.candidate;
    stage[0].acc   = '0;
    stage[0].wf    = '0;
  end

  // round cells
  for (genvar i = 0; i < NCells; i++) begin : g_cell
    sdc_cell #(.Idx(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .first_word (first_word),
      .prev       (stage[i]),
      .cur        (stage[i+1])
    );
  end

  sdc_outbuf u_outbuf (
    .clk  (clk),
    .rst  (rst),
    .last (stage[NCells]),
    .en   (en),
    .full (full),
    .out  (out)
  );

  // checks
  a_hit_matches: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> (out.hit == (out.round17_difference == '0)))
    else $error("hit flag disagrees with difference");
  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready && !in.ready) |=> !in.ready)
    else $error("input reopened while buffer stayed full");
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> out.valid && $stable(out.candidate_echo))
    else $error("stalled result changed");
  a_ready_buffer: assert property (@(posedge clk) disable iff (rst)
    !in.ready |-> out.valid)
    else $error("input blocked with empty buffer");

endmodule
